// ===== rtl/pmc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the page mapping cache: outcome and register codes, controller
// state type and the command/status structs between controller and datapath.
// No dependencies.
package pmc_pkg;

    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned OUTC_W  = 2;

    typedef logic [OUTC_W-1:0] t_outcome;

    localparam t_outcome OUT_LOW  = 2'd0;
    localparam t_outcome OUT_HIT  = 2'd1;
    localparam t_outcome OUT_NEW  = 2'd2;
    localparam t_outcome OUT_FAIL = 2'd3;

    typedef logic [IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_WINDOW_BASE  = 8'd0;
    localparam t_reg_idx REG_WINDOW_LIMIT = 8'd1;
    localparam t_reg_idx REG_LOW_LIMIT    = 8'd2;
    localparam t_reg_idx REG_LOW_OFFSET   = 8'd3;

    localparam logic [ADDR_W-1:0] LOW_LIMIT_RST  = 64'h0000_0000_0040_0000;
    localparam logic [ADDR_W-1:0] LOW_OFFSET_RST = 64'hFFFF_FFFF_8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DONE
    } t_pmc_state;

    typedef struct packed {
        logic latch_in;    // capture the request beat
        logic set_low;     // result is the direct low mapping
        logic scan_start;  // clear the scan pointer
        logic scan;        // issue the next table read
        logic take_hit;    // result from the matching entry
        logic alloc;       // allocate a window page, or fail
        logic load_out;    // move the result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic low;
        logic hit;
        logic miss;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/pmc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the page mapping cache.
// Depends on pmc_pkg for the state type and command/status structs.
module pmc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  pmc_pkg::t_dp_sts i_sts,
    output pmc_pkg::t_dp_cmd o_cmd
);

    pmc_pkg::t_pmc_state r_state;
    pmc_pkg::t_pmc_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            pmc_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = pmc_pkg::ST_CHECK;
                end
            end
            pmc_pkg::ST_CHECK: begin
                if (i_sts.low) begin
                    o_cmd.set_low = 1'b1;
                    n_state       = pmc_pkg::ST_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = pmc_pkg::ST_SCAN;
                end
            end
            pmc_pkg::ST_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = pmc_pkg::ST_DONE;
                end else if (i_sts.miss) begin
                    o_cmd.alloc = 1'b1;
                    n_state     = pmc_pkg::ST_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            pmc_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = pmc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pmc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pmc_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the page mapping cache: configuration registers, mapping table
// memory with its scan pointer, allocator and the output register.
// Depends on pmc_pkg; driven by pmc_ctrl through command/status structs.
module pmc_dp #(
    parameter int unsigned ENTRIES   = 64,
    parameter int unsigned PAGE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  pmc_pkg::t_reg_idx     i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    input  logic [63:0]           i_phys,
    input  pmc_pkg::t_dp_cmd      i_cmd,
    output pmc_pkg::t_dp_sts      o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [63:0]           o_out_addr,
    output pmc_pkg::t_outcome     o_out_outcome
);

    localparam int unsigned PW = 64 - PAGE_BITS;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [63:0] PAGE_SIZE = 64'(1) << PAGE_BITS;

    logic [63:0] r_win_limit;
    logic [63:0] r_low_limit;
    logic [63:0] r_low_offset;
    logic [63:0] r_next_win;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_rd_vld;
    logic [2*PW-1:0] r_rd_data;
    logic [63:0]   r_phys;
    logic [63:0]   r_res_addr;
    pmc_pkg::t_outcome r_res_outcome;
    logic          r_out_vld;
    logic [63:0]   r_out_addr;
    pmc_pkg::t_outcome r_out_outcome;

    // Each entry holds {physical page, virtual page}.
    logic [2*PW-1:0] r_mem [ENTRIES];

    logic rd_en;
    logic table_full;
    logic win_done;
    logic alloc_ok;

    assign rd_en      = i_cmd.scan && (r_idx < r_count);
    assign table_full = (r_count == CW'(ENTRIES));
    assign win_done   = (r_next_win == r_win_limit);
    assign alloc_ok   = i_cmd.alloc && !table_full && !win_done;

    assign o_sts.low      = (r_phys <= r_low_limit);
    assign o_sts.hit      = r_rd_vld && (r_rd_data[2*PW-1:PW] == r_phys[63:PAGE_BITS]);
    assign o_sts.miss     = !r_rd_vld && (r_idx == r_count);
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (alloc_ok) begin
            r_mem[r_count[AW-1:0]] <= {r_phys[63:PAGE_BITS], r_next_win[63:PAGE_BITS]};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_limit  <= '0;
            r_low_limit  <= pmc_pkg::LOW_LIMIT_RST;
            r_low_offset <= pmc_pkg::LOW_OFFSET_RST;
            r_next_win   <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pmc_pkg::REG_WINDOW_BASE:  r_next_win   <= i_cfg_data;
                    pmc_pkg::REG_WINDOW_LIMIT: r_win_limit  <= i_cfg_data;
                    pmc_pkg::REG_LOW_LIMIT:    r_low_limit  <= i_cfg_data;
                    pmc_pkg::REG_LOW_OFFSET:   r_low_offset <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.scan_start) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= rd_en;
                if (rd_en) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            if (alloc_ok) begin
                r_count    <= r_count + CW'(1);
                r_next_win <= r_next_win + PAGE_SIZE;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_phys <= i_phys;
        end
        if (i_cmd.set_low) begin
            r_res_addr    <= r_phys | r_low_offset;
            r_res_outcome <= pmc_pkg::OUT_LOW;
        end else if (i_cmd.take_hit) begin
            r_res_addr    <= {r_rd_data[PW-1:0], r_phys[PAGE_BITS-1:0]};
            r_res_outcome <= pmc_pkg::OUT_HIT;
        end else if (i_cmd.alloc) begin
            if (alloc_ok) begin
                r_res_addr    <= {r_next_win[63:PAGE_BITS], r_phys[PAGE_BITS-1:0]};
                r_res_outcome <= pmc_pkg::OUT_NEW;
            end else begin
                r_res_addr    <= '0;
                r_res_outcome <= pmc_pkg::OUT_FAIL;
            end
        end
        if (i_cmd.load_out) begin
            r_out_addr    <= r_res_addr;
            r_out_outcome <= r_res_outcome;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_out_addr    = r_out_addr;
    assign o_out_outcome = r_out_outcome;

endmodule

// ===== rtl/page_mapping_cache.sv =====
`timescale 1ns / 1ps
// Top level of the page mapping cache: joins controller and datapath.
// Depends on pmc_pkg, pmc_ctrl and pmc_dp.
//
// Usage: each beat on the s_axis channel carries one physical address. Each
// request yields exactly one beat on m_axis: the virtual address in tdata and
// the outcome code in tuser (low direct, table hit, new mapping, failed).
// Configuration registers are written on the cfg channel (index, data), which
// is always ready; write them only while no request is in flight.
//
// Timing: one request is handled at a time. A low-region address goes from
// the check state to the done state, then to the output register. A table
// lookup reads the mapping memory one entry per cycle. The next request is
// accepted as soon as the result has moved to the output register, even if
// that beat has not been taken yet. When the receiver stalls, the output
// register holds its beat and a second finished result waits inside the
// block until the register frees up. Reset clears the control state and the
// entry count, restores the register reset values and points the allocator
// at address zero; the table needs no clearing pass since only counted
// entries are read.
module page_mapping_cache #(
    parameter int unsigned ENTRIES   = 64,
    parameter int unsigned PAGE_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] paddr
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] virt_addr
    output logic [1:0]  m_axis_tuser,   // [1:0] outcome
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    pmc_pkg::t_dp_cmd dp_cmd;
    pmc_pkg::t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    pmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    pmc_dp #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_phys        (s_axis_tdata),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_addr    (m_axis_tdata),
        .o_out_outcome (m_axis_tuser)
    );

    // A failed request always reports address zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == pmc_pkg::OUT_FAIL) |-> (m_axis_tdata == 64'd0))
        else $error("failed result carries a nonzero address");

    // Only one request is in flight: intake closes right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // A result never overwrites an output beat that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten while stalled");

endmodule

// ===== test/page_mapping_cache_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for page_mapping_cache: a translation scoreboard predicts every
// result beat while plain tasks drive the request and register channels with varying idling.
// Depends on pmc_pkg and the page_mapping_cache RTL.
module page_mapping_cache_test;

    localparam int unsigned N_ENT       = 64;
    localparam int unsigned PG_BITS     = 12;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned PHASE_ITEMS = 260;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    // Indexes the block must ignore.
    localparam pmc_pkg::t_reg_idx REG_SPARE_LO = 8'd4;
    localparam pmc_pkg::t_reg_idx REG_SPARE_HI = 8'hFF;

    typedef struct packed {
        logic [63:0]       va;
        pmc_pkg::t_outcome oc;
    } t_xlate;

    // Tracks registers, mapping table and allocator, and holds the translations
    // still owed by the block in request order.
    class xlate_board;
        logic [63:0]        win_base, win_limit, low_lim, low_off, next_va;
        logic [63:PG_BITS]  phys_pg [N_ENT];
        logic [63:PG_BITS]  virt_pg [N_ENT];
        int unsigned        n_entries, n_errors, n_checked;
        int unsigned        n_by_outcome [4];
        t_xlate             owed [$];

        function new();
            win_base  = '0;
            win_limit = '0;
            low_lim   = pmc_pkg::LOW_LIMIT_RST;
            low_off   = pmc_pkg::LOW_OFFSET_RST;
            next_va   = '0;
            n_entries = 0;
            n_errors  = 0;
            n_checked = 0;
            foreach (n_by_outcome[i]) n_by_outcome[i] = 0;
        endfunction

        function void write_reg(pmc_pkg::t_reg_idx idx, logic [63:0] v);
            case (idx)
                pmc_pkg::REG_WINDOW_BASE: begin
                    win_base = v;
                    next_va  = v;
                end
                pmc_pkg::REG_WINDOW_LIMIT: win_limit = v;
                pmc_pkg::REG_LOW_LIMIT:    low_lim   = v;
                pmc_pkg::REG_LOW_OFFSET:   low_off   = v;
                default: ;
            endcase
        endfunction

        function void note_request(logic [63:0] pa);
            t_xlate            r;
            logic [63:PG_BITS] pg;
            bit                found;
            pg    = pa[63:PG_BITS];
            found = 1'b0;
            r.va  = '0;
            r.oc  = pmc_pkg::OUT_FAIL;
            if (pa <= low_lim) begin
                r.va = pa | low_off;
                r.oc = pmc_pkg::OUT_LOW;
            end else begin
                for (int unsigned i = 0; i < n_entries && !found; i++) begin
                    if (phys_pg[i] == pg) begin
                        r.va  = {virt_pg[i], pa[PG_BITS-1:0]};
                        r.oc  = pmc_pkg::OUT_HIT;
                        found = 1'b1;
                    end
                end
                // A miss allocates only while the window is open and the table has room.
                if (!found && next_va != win_limit && n_entries < N_ENT) begin
                    phys_pg[n_entries] = pg;
                    virt_pg[n_entries] = next_va[63:PG_BITS];
                    r.va = {next_va[63:PG_BITS], pa[PG_BITS-1:0]};
                    r.oc = pmc_pkg::OUT_NEW;
                    n_entries++;
                    next_va += 64'd1 << PG_BITS;
                end
            end
            owed.push_back(r);
        endfunction

        function void check_result(logic [63:0] va, pmc_pkg::t_outcome oc);
            t_xlate w;
            if (owed.size() == 0) begin
                n_errors++;
                $error("result beat with no request waiting: virt_addr %h outcome %0d", va, oc);
                return;
            end
            w = owed.pop_front();
            n_checked++;
            n_by_outcome[w.oc]++;
            if (va !== w.va) begin
                n_errors++;
                $error("virt_addr mismatch: expected %h, actual %h", w.va, va);
            end
            if (oc !== w.oc) begin
                n_errors++;
                $error("outcome mismatch: expected %0d, actual %0d", w.oc, oc);
            end
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    pmc_pkg::t_reg_idx i_cfg_index = '0;
    logic [63:0]       i_cfg_data = '0;

    xlate_board        board = new();
    logic [63:PG_BITS] seen_pages [$];
    int unsigned       tx_idle_pct = 0;
    int unsigned       rx_stall_pct = 0;
    int unsigned       cycles = 0;

    page_mapping_cache #(
        .ENTRIES   (N_ENT),
        .PAGE_BITS (PG_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("page_mapping_cache_test: errors");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick the next ready level.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mix of low-region addresses, revisits of pages already sent, fresh pages
    // and boundary values.
    function automatic logic [63:0] next_addr();
        logic [63:0] a;
        int unsigned pick;
        pick = $urandom_range(99);
        a    = rand64();
        if (pick < 25) begin
            if (board.low_lim != ALL_ONES) a = a % (board.low_lim + 64'd1);
        end else if (pick < 70) begin
            if (seen_pages.size() != 0)
                a = {seen_pages[$urandom_range(seen_pages.size() - 1)], a[PG_BITS-1:0]};
        end else if (pick >= 85) begin
            case ($urandom_range(4))
                0: a = '0;
                1: a = ALL_ONES;
                2: a = board.low_lim;
                3: a = board.low_lim + 64'd1;
                default: a = 64'd1 << $urandom_range(63);
            endcase
        end
        return a;
    endfunction

    // Leaves tvalid high after the beat so back-to-back requests need no toggle.
    task automatic send_addr(input logic [63:0] a);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= a;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(a);
        if (a > board.low_lim) seen_pages.push_back(a[63:PG_BITS]);
    endtask

    task automatic cfg_write(input pmc_pkg::t_reg_idx idx, input logic [63:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Drain, then let the block return to idle.
    task automatic settle();
        drain();
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_random(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            send_addr(next_addr());
            if (k == n / 2) begin
                drain();
            end else if ($urandom_range(99) < tx_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
            end
        end
    endtask

    initial begin
        logic [63:0] base;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty window, so any miss fails at once.
        send_addr(64'h0);
        send_addr(pmc_pkg::LOW_LIMIT_RST);
        send_addr(pmc_pkg::LOW_LIMIT_RST + 64'd1);
        send_addr(ALL_ONES);
        settle();

        // Unaligned window just below the top of the address space; it wraps
        // and closes after four pages.
        cfg_write(REG_SPARE_LO, ALL_ONES);
        cfg_write(REG_SPARE_HI, ALL_ONES);
        cfg_write(pmc_pkg::REG_WINDOW_LIMIT, 64'h0000_0000_0000_2123);
        cfg_write(pmc_pkg::REG_WINDOW_BASE, 64'hFFFF_FFFF_FFFF_E123);
        cfg_write(pmc_pkg::REG_LOW_LIMIT, 64'h0);
        cfg_write(pmc_pkg::REG_LOW_OFFSET, ALL_ONES);
        send_addr(64'h0);
        send_addr(64'h1);
        send_addr(64'hFFF);
        send_addr(ALL_ONES);
        send_addr(64'h8000_0000_0000_0ABC);
        send_addr(64'h0000_1000_0000_0000);
        send_addr(64'h0000_2000_0000_0000);
        send_addr(ALL_ONES);
        send_addr(64'hFFFF_FFFF_FFFF_F000);
        settle();

        // Everything falls in the low region, with no offset applied.
        cfg_write(pmc_pkg::REG_LOW_LIMIT, ALL_ONES);
        cfg_write(pmc_pkg::REG_LOW_OFFSET, 64'h0);
        send_addr(ALL_ONES);
        send_addr(64'h5555_AAAA_5555_AAAA);
        send_addr(64'hAAAA_5555_AAAA_5555);

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    cfg_write(pmc_pkg::REG_WINDOW_BASE, 64'h0000_7F00_0000_0000);
                    cfg_write(pmc_pkg::REG_WINDOW_LIMIT, 64'hFFFF_FFFF_FFFF_F000);
                    cfg_write(pmc_pkg::REG_LOW_LIMIT, pmc_pkg::LOW_LIMIT_RST);
                    cfg_write(pmc_pkg::REG_LOW_OFFSET, pmc_pkg::LOW_OFFSET_RST);
                end
                1: begin
                    // Short window: exhausted within the phase unless the table fills first.
                    tx_idle_pct  = 82;
                    rx_stall_pct = 0;
                    base = rand64();
                    cfg_write(pmc_pkg::REG_WINDOW_BASE, base);
                    cfg_write(pmc_pkg::REG_WINDOW_LIMIT, base + (64'd8 << PG_BITS));
                    cfg_write(pmc_pkg::REG_LOW_LIMIT, {32'h0, $urandom});
                    cfg_write(pmc_pkg::REG_LOW_OFFSET, rand64());
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 82;
                    cfg_write(pmc_pkg::REG_WINDOW_BASE, 64'h0);
                    cfg_write(pmc_pkg::REG_WINDOW_LIMIT, 64'h0000_0000_1000_0000);
                    cfg_write(pmc_pkg::REG_LOW_LIMIT, 64'h0);
                    cfg_write(pmc_pkg::REG_LOW_OFFSET, 64'h0);
                end
                default: begin
                    // Base equal to limit: the window is closed from the start.
                    tx_idle_pct  = 12;
                    rx_stall_pct = 12;
                    cfg_write(pmc_pkg::REG_WINDOW_BASE, ALL_ONES);
                    cfg_write(pmc_pkg::REG_WINDOW_LIMIT, ALL_ONES);
                    cfg_write(pmc_pkg::REG_LOW_LIMIT, 64'h7FFF_FFFF_FFFF_FFFF);
                    cfg_write(pmc_pkg::REG_LOW_OFFSET, rand64());
                end
            endcase
            run_random(PHASE_ITEMS);
        end

        settle();
        repeat (70) @(posedge i_clk);
        if (board.pending() != 0) begin
            board.n_errors++;
            $error("%0d translations never returned", board.pending());
        end

        $display("summary: %0d translations checked: %0d low, %0d hit, %0d new, %0d failed",
                 board.n_checked, board.n_by_outcome[pmc_pkg::OUT_LOW],
                 board.n_by_outcome[pmc_pkg::OUT_HIT],
                 board.n_by_outcome[pmc_pkg::OUT_NEW], board.n_by_outcome[pmc_pkg::OUT_FAIL]);
        $display("summary: %0d of %0d table entries filled over seven register settings",
                 board.n_entries, N_ENT);
        if (board.n_errors == 0) begin
            $display("page_mapping_cache_test: clean");
        end else begin
            $display("page_mapping_cache_test: errors");
        end
        $finish;
    end

endmodule
